// ----- hw/rtl/c2p_pkg.sv -----
// c2p_pkg: shared widths, constants, arctangent table and pipeline item type
// for the cartesian to polar converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package c2p_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int CORDIC_EFF    = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int SQRT_STEPS    = 16;
  localparam int NSTG          = (CORDIC_EFF > SQRT_STEPS) ? CORDIC_EFF : SQRT_STEPS;

  localparam int COORD_W    = 16;
  localparam int COORD_FRAC = 20;
  localparam int CW         = 40;
  localparam int AW         = 26;
  localparam int SUM_W      = 32;
  localparam int SQ_W       = 31;
  localparam int RW         = 34;
  localparam int RAD_W      = 16;
  localparam int ANG_W      = 16;
  localparam int QUAD_W     = 3;
  localparam int ANG_SHIFT  = 9;

  localparam logic signed [ANG_W-1:0] HALF_TURN    = 16'sd23040;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 16'sd11520;
  localparam logic signed [AW-1:0]    ACC_QUARTER  = 26'sd5898240;
  localparam logic signed [AW:0]      ROUND_BIAS   = 27'sd256;

  typedef enum logic [QUAD_W-1:0] {
    QUAD_AXIS = 3'd0,
    QUAD_1    = 3'd1,
    QUAD_2    = 3'd2,
    QUAD_3    = 3'd3,
    QUAD_4    = 3'd4
  } quad_t;

  localparam logic signed [AW-1:0] ATAN_TAB [TABLE_LEN] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0
  };

  typedef struct packed {
    logic signed [CW-1:0]    cx;
    logic signed [CW-1:0]    cy;
    logic signed [AW-1:0]    acc;
    logic [RAD_W-1:0]        root;
    logic [SUM_W-1:0]        rem;
    quad_t                   quad;
    logic                    spec;
    logic signed [ANG_W-1:0] spec_ang;
  } item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cartesian_to_polar_with_quadrant.sv -----
// cartesian_to_polar_with_quadrant: top level of the converter.
// Depends on c2p_pkg, c2p_prep, c2p_iter and c2p_final.
//
// Usage:
//   input: drive in_x_coord / in_y_coord and raise start; a transfer happens
//   at each rising edge with start high and busy low. busy is always low,
//   so a new point may be given on every cycle.
//   output: out_valid is high for one cycle per point, with
//   out_quadrant_code, out_radius and out_angle (1/128 degree) beside it.
//   Results leave in the order the points came in.
// Depth: the iteration chain has NSTG stages, where NSTG is the larger of
//   the cordic stage count and the 16 square root digits.
// Throughput: one point per cycle, set by the unrolled stage chain: two front
//   stages (squares and pre-rotation, then sum), one stage per iteration,
//   one output stage.
// Reset: rst_n clears all valid bits; points in flight are dropped and
//   out_valid stays low until new points arrive.
// Stalls: the receiver cannot hold results off; nothing waits in the block.
`timescale 1ns / 1ps
`default_nettype none

module cartesian_to_polar_with_quadrant (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [c2p_pkg::COORD_W-1:0] in_x_coord,
  input  wire logic signed [c2p_pkg::COORD_W-1:0] in_y_coord,
  output logic                                   out_valid,
  output logic [c2p_pkg::QUAD_W-1:0]             out_quadrant_code,
  output logic [c2p_pkg::RAD_W-1:0]              out_radius,
  output logic signed [c2p_pkg::ANG_W-1:0]       out_angle
);

  logic           accept;
  logic           prep_vld;
  c2p_pkg::item_t prep_item;
  logic           iter_vld;
  c2p_pkg::item_t iter_item;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  c2p_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (accept),
    .x_i    (in_x_coord),
    .y_i    (in_y_coord),
    .vld_o  (prep_vld),
    .item_o (prep_item)
  );

  c2p_iter u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (prep_vld),
    .item_i (prep_item),
    .vld_o  (iter_vld),
    .item_o (iter_item)
  );

  c2p_final u_final (
    .clk               (clk),
    .rst_n             (rst_n),
    .vld_i             (iter_vld),
    .item_i            (iter_item),
    .out_valid         (out_valid),
    .out_quadrant_code (out_quadrant_code),
    .out_radius        (out_radius),
    .out_angle         (out_angle)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/c2p_prep.sv -----
// c2p_prep: front stages - quadrant, axis angles, pre-rotation, squares,
// then sum of squares. Depends on c2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c2p_prep (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            vld_i,
  input  wire logic signed [c2p_pkg::COORD_W-1:0] x_i,
  input  wire logic signed [c2p_pkg::COORD_W-1:0] y_i,
  output logic                                 vld_o,
  output c2p_pkg::item_t                       item_o
);

  localparam int CW      = c2p_pkg::CW;
  localparam int COORD_W = c2p_pkg::COORD_W;
  localparam int FRAC    = c2p_pkg::COORD_FRAC;
  localparam int SQ_W    = c2p_pkg::SQ_W;
  localparam int SUM_W   = c2p_pkg::SUM_W;

  logic                     a_vld_r;
  c2p_pkg::item_t           a_item_r, a_item_nxt;
  logic [SQ_W-1:0]          xx_r, yy_r;
  logic signed [2*COORD_W-1:0] xx_nxt, yy_nxt;
  logic                     b_vld_r;
  c2p_pkg::item_t           b_item_r, b_item_nxt;
  logic signed [CW-1:0]     xs, ys;

  assign xx_nxt = x_i * x_i;
  assign yy_nxt = y_i * y_i;

  always_comb begin
    xs = {{(CW-COORD_W-FRAC){x_i[COORD_W-1]}}, x_i, {FRAC{1'b0}}};
    ys = {{(CW-COORD_W-FRAC){y_i[COORD_W-1]}}, y_i, {FRAC{1'b0}}};
    a_item_nxt      = '0;
    a_item_nxt.cx   = xs;
    a_item_nxt.cy   = ys;
    a_item_nxt.acc  = '0;
    if (xs[CW-1]) begin
      if (!ys[CW-1]) begin
        a_item_nxt.cx  = ys;
        a_item_nxt.cy  = -xs;
        a_item_nxt.acc = c2p_pkg::ACC_QUARTER;
      end else begin
        a_item_nxt.cx  = -ys;
        a_item_nxt.cy  = xs;
        a_item_nxt.acc = -c2p_pkg::ACC_QUARTER;
      end
    end
    if (x_i == '0 || y_i == '0) begin
      a_item_nxt.quad = c2p_pkg::QUAD_AXIS;
    end else if (!x_i[COORD_W-1]) begin
      a_item_nxt.quad = y_i[COORD_W-1] ? c2p_pkg::QUAD_4 : c2p_pkg::QUAD_1;
    end else begin
      a_item_nxt.quad = y_i[COORD_W-1] ? c2p_pkg::QUAD_3 : c2p_pkg::QUAD_2;
    end
    a_item_nxt.spec = (x_i == '0) || (y_i == '0);
    if (y_i == '0) begin
      a_item_nxt.spec_ang = x_i[COORD_W-1] ? c2p_pkg::HALF_TURN : '0;
    end else begin
      a_item_nxt.spec_ang = y_i[COORD_W-1] ? -c2p_pkg::QUARTER_TURN : c2p_pkg::QUARTER_TURN;
    end
  end

  always_comb begin
    b_item_nxt      = a_item_r;
    b_item_nxt.root = '0;
    b_item_nxt.rem  = SUM_W'(xx_r) + SUM_W'(yy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= vld_i;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_item_r <= a_item_nxt;
    xx_r     <= xx_nxt[SQ_W-1:0];
    yy_r     <= yy_nxt[SQ_W-1:0];
    b_item_r <= b_item_nxt;
  end

  assign vld_o  = b_vld_r;
  assign item_o = b_item_r;

endmodule

`default_nettype wire

// ----- hw/rtl/c2p_iter.sv -----
// c2p_iter: unrolled iteration stages, at most one cordic vectoring step and
// one square root digit per register stage. Depends on c2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c2p_iter (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           vld_i,
  input  c2p_pkg::item_t      item_i,
  output logic                vld_o,
  output c2p_pkg::item_t      item_o
);

  localparam int NSTG   = c2p_pkg::NSTG;
  localparam int CW     = c2p_pkg::CW;
  localparam int AW     = c2p_pkg::AW;
  localparam int RW     = c2p_pkg::RW;
  localparam int RAD_W  = c2p_pkg::RAD_W;
  localparam int SUM_W  = c2p_pkg::SUM_W;
  localparam int SQRT_N = c2p_pkg::SQRT_STEPS;
  localparam int CORD_N = c2p_pkg::CORDIC_EFF;

  logic           vld_r    [NSTG];
  c2p_pkg::item_t item_r   [NSTG];
  c2p_pkg::item_t item_nxt [NSTG];
  logic           src_vld  [NSTG];
  c2p_pkg::item_t src      [NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    localparam int B = (g < SQRT_N) ? SQRT_N - 1 - g : 0;
    localparam int T = (g < CORD_N) ? g : 0;

    logic signed [CW-1:0] cx, cy, dx, dy;
    logic signed [AW-1:0] acc;
    logic [RW-1:0]        remx, sub;

    if (g == 0) begin : g_first
      assign src_vld[g] = vld_i;
      assign src[g]     = item_i;
    end else begin : g_next
      assign src_vld[g] = vld_r[g-1];
      assign src[g]     = item_r[g-1];
    end

    always_comb begin
      cx   = src[g].cx;
      cy   = src[g].cy;
      acc  = src[g].acc;
      dx   = cy >>> T;
      dy   = cx >>> T;
      remx = {{(RW-SUM_W){1'b0}}, src[g].rem};
      sub  = ({{(RW-RAD_W){1'b0}}, src[g].root} << (B + 1)) + ({{(RW-1){1'b0}}, 1'b1} << (2 * B));
      item_nxt[g] = src[g];
      if (g < CORD_N) begin
        if (!cy[CW-1]) begin
          item_nxt[g].cx  = cx + dx;
          item_nxt[g].cy  = cy - dy;
          item_nxt[g].acc = acc + c2p_pkg::ATAN_TAB[T];
        end else begin
          item_nxt[g].cx  = cx - dx;
          item_nxt[g].cy  = cy + dy;
          item_nxt[g].acc = acc - c2p_pkg::ATAN_TAB[T];
        end
      end
      if (g < SQRT_N) begin
        if (remx >= sub) begin
          item_nxt[g].rem  = SUM_W'(remx - sub);
          item_nxt[g].root = src[g].root | (RAD_W'(1) << B);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= src_vld[g];
      end
    end

    always_ff @(posedge clk) begin
      item_r[g] <= item_nxt[g];
    end
  end

  assign vld_o  = vld_r[NSTG-1];
  assign item_o = item_r[NSTG-1];

endmodule

`default_nettype wire

// ----- hw/rtl/c2p_final.sv -----
// c2p_final: output stage - angle rounding and clamp, axis override,
// radius rounding, registered result with strobe. Depends on c2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c2p_final (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         vld_i,
  input  c2p_pkg::item_t                    item_i,
  output logic                              out_valid,
  output logic [c2p_pkg::QUAD_W-1:0]        out_quadrant_code,
  output logic [c2p_pkg::RAD_W-1:0]         out_radius,
  output logic signed [c2p_pkg::ANG_W-1:0]  out_angle
);

  localparam int AW    = c2p_pkg::AW;
  localparam int ANG_W = c2p_pkg::ANG_W;
  localparam int RAD_W = c2p_pkg::RAD_W;
  localparam int SUM_W = c2p_pkg::SUM_W;

  logic signed [AW:0]        biased, shifted;
  logic signed [AW:0]        half_ext;
  logic signed [ANG_W-1:0]   ang_nxt;
  logic [RAD_W-1:0]          rad_nxt;
  logic                      valid_r;
  logic [c2p_pkg::QUAD_W-1:0] quad_r;
  logic [RAD_W-1:0]          rad_r;
  logic signed [ANG_W-1:0]   ang_r;

  always_comb begin
    biased   = {item_i.acc[AW-1], item_i.acc} + c2p_pkg::ROUND_BIAS;
    shifted  = biased >>> c2p_pkg::ANG_SHIFT;
    half_ext = {{(AW+1-ANG_W){1'b0}}, c2p_pkg::HALF_TURN};
    if (shifted > half_ext) begin
      ang_nxt = c2p_pkg::HALF_TURN;
    end else if (shifted < -half_ext) begin
      ang_nxt = -c2p_pkg::HALF_TURN;
    end else begin
      ang_nxt = shifted[ANG_W-1:0];
    end
    if (item_i.spec) begin
      ang_nxt = item_i.spec_ang;
    end
    rad_nxt = item_i.root;
    if (item_i.rem > {{(SUM_W-RAD_W){1'b0}}, item_i.root}) begin
      rad_nxt = item_i.root + RAD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    quad_r <= item_i.quad;
    rad_r  <= rad_nxt;
    ang_r  <= ang_nxt;
  end

  assign out_valid         = valid_r;
  assign out_quadrant_code = quad_r;
  assign out_radius        = rad_r;
  assign out_angle         = ang_r;

endmodule

`default_nettype wire
